// ===== rtl/core/lmd_pkg.sv =====
// Shared types and constants for the local minima detector.
// Used by the front, the result queue, the back end and the top level.
package lmd_pkg;

	localparam int INDEX_BITS = 16;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		SLOPE_ZERO = 2'd0,
		SLOPE_UP   = 2'd1,
		SLOPE_DOWN = 2'd2
	} slope_t;

	// One or two minima found by a single sample.
	typedef struct packed {
		logic                  two;
		logic [INDEX_BITS-1:0] first;
		logic [INDEX_BITS-1:0] second;
	} result_pair_t;

	// Head of the result queue as the back end sees it.
	typedef struct packed {
		logic         empty;
		result_pair_t head;
	} queue_head_t;

endpackage

// ===== rtl/core/local_minima_detector_unit.sv =====
// Top level of the local minima detector: front, result queue and back end.
// Depends on lmd_pkg, lmd_front, lmd_queue and lmd_back.
//
//   channel   direction  handshake     payload
//   input     in         push / full   sample, last
//   result    out        pop / empty   min_index, last_of_run
//
// One sample is accepted per cycle while full is low; its minima are in the queue the next cycle.
// A sample that finds a flat valley yields two beats, all others at most one;
// the result side delivers one beat per cycle while pop is high, and the queue absorbs the extra beat.
// full rises only when four result pairs wait; until then samples keep flowing while pop is low.
// Reset clears the slope state, the sample counter and the queue.
module local_minima_detector_unit
	import lmd_pkg::*;
#(
	parameter int SAMPLE_BITS = 16,
	parameter int MAX_LEN = 65536
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          last,
	output logic                          empty,
	input  logic                          pop,
	output logic [INDEX_BITS-1:0]         min_index,
	output logic                          last_of_run
);

	logic         take;
	logic         wr;
	result_pair_t wr_data;
	logic         rd;
	queue_head_t  head;

	assign take = push && !full;

	lmd_front #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.MAX_LEN(MAX_LEN)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.take(take),
		.sample(sample),
		.last(last),
		.wr(wr),
		.wr_data(wr_data)
	);

	lmd_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr(wr),
		.wr_data(wr_data),
		.rd(rd),
		.full(full),
		.head(head)
	);

	lmd_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.pop(pop),
		.rd(rd),
		.empty(empty),
		.min_index(min_index),
		.last_of_run(last_of_run)
	);

	// The second beat of a pair follows the first without a gap.
	a_pair_stays: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && !last_of_run) |=> !empty)
		else $error("second beat of a result pair went missing");

	// Results appear only after an accepted sample.
	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		(empty && !(push && !full)) |=> empty)
		else $error("result appeared without an accepted sample");

	// A full queue always has a result to offer.
	a_full_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !empty)
		else $error("queue reports full and empty together");

endmodule

// ===== rtl/core/lmd_front.sv =====
// Front end: tracks slopes and flat runs, classifies each sample and
// produces the minima it reveals. Depends on lmd_pkg.
module lmd_front
	import lmd_pkg::*;
#(
	parameter int SAMPLE_BITS = 16,
	parameter int MAX_LEN = 65536
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          take,
	input  logic signed [SAMPLE_BITS-1:0] sample,
	input  logic                          last,
	output logic                          wr,
	output result_pair_t                  wr_data
);

	localparam int CW = $clog2(MAX_LEN);
	localparam int IW = (CW > INDEX_BITS) ? CW : INDEX_BITS;
	localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_LEN - 1);

	logic signed [SAMPLE_BITS-1:0] prev_q;
	slope_t                        left_slope_q;
	logic                          in_flat_q;
	slope_t                        entry_slope_q;
	logic [CW-1:0]                 flat_start_q;
	logic [CW-1:0]                 count_q;

	slope_t        d;
	logic          c_nz, c_one, c_many;
	logic [CW-1:0] i_idx;
	logic [IW-1:0] i_ext, c_ext, s_ext;
	logic          valley_exit, first_min, plain_min, end_min;

	assign c_nz   = (count_q != '0);
	assign c_one  = (count_q == CW'(1));
	assign c_many = c_nz && !c_one;
	assign i_idx  = count_q - CW'(1);

	always_comb begin
		if (sample > prev_q)
			d = SLOPE_UP;
		else if (sample < prev_q)
			d = SLOPE_DOWN;
		else
			d = SLOPE_ZERO;
	end

	assign valley_exit = c_many && in_flat_q && entry_slope_q == SLOPE_DOWN && d == SLOPE_UP;
	assign first_min   = c_one && d == SLOPE_UP;
	assign plain_min   = c_many && !in_flat_q && left_slope_q == SLOPE_DOWN && d == SLOPE_UP;
	assign end_min     = last && c_nz && d == SLOPE_DOWN;

	assign i_ext = IW'(i_idx);
	assign c_ext = IW'(count_q);
	assign s_ext = IW'(flat_start_q);

	// The four cases exclude each other, so at most one of them fires.
	always_comb begin
		wr_data.two    = valley_exit;
		wr_data.second = i_ext[INDEX_BITS-1:0];
		priority if (valley_exit)
			wr_data.first = s_ext[INDEX_BITS-1:0];
		else if (first_min)
			wr_data.first = '0;
		else if (plain_min)
			wr_data.first = i_ext[INDEX_BITS-1:0];
		else
			wr_data.first = c_ext[INDEX_BITS-1:0];
	end

	assign wr = take && (valley_exit || first_min || plain_min || end_min);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q        <= '0;
			left_slope_q  <= SLOPE_ZERO;
			in_flat_q     <= 1'b0;
			entry_slope_q <= SLOPE_ZERO;
			flat_start_q  <= '0;
			count_q       <= '0;
		end else if (take) begin
			if (last) begin
				prev_q        <= '0;
				left_slope_q  <= SLOPE_ZERO;
				in_flat_q     <= 1'b0;
				entry_slope_q <= SLOPE_ZERO;
				flat_start_q  <= '0;
				count_q       <= '0;
			end else begin
				prev_q <= sample;
				if (c_nz)
					left_slope_q <= d;
				if (c_many) begin
					in_flat_q <= (d == SLOPE_ZERO);
					// A new flat run starts here and remembers how it was entered.
					if (!in_flat_q && d == SLOPE_ZERO) begin
						entry_slope_q <= left_slope_q;
						flat_start_q  <= i_idx;
					end
				end
				if (count_q != COUNT_MAX)
					count_q <= count_q + CW'(1);
			end
		end
	end

endmodule

// ===== rtl/core/lmd_queue.sv =====
// Short queue of result pairs between the front and the back end.
// Depends on lmd_pkg.
module lmd_queue
	import lmd_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr,
	input  result_pair_t wr_data,
	input  logic         rd,
	output logic         full,
	output queue_head_t  head
);

	result_pair_t        entries_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_BITS-1:0] count_q;

	assign full       = (count_q == QCNT_BITS'(QUEUE_DEPTH));
	assign head.empty = (count_q == '0);
	assign head.head  = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr)
			entries_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr)
				wr_ptr_q <= (wr_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
					: wr_ptr_q + QPTR_BITS'(1);
			if (rd)
				rd_ptr_q <= (rd_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0
					: rd_ptr_q + QPTR_BITS'(1);
			if (wr && !rd)
				count_q <= count_q + QCNT_BITS'(1);
			else if (rd && !wr)
				count_q <= count_q - QCNT_BITS'(1);
		end
	end

endmodule

// ===== rtl/core/lmd_back.sv =====
// Back end: splits each queued result pair into one or two output beats.
// Depends on lmd_pkg.
module lmd_back
	import lmd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  queue_head_t           head,
	input  logic                  pop,
	output logic                  rd,
	output logic                  empty,
	output logic [INDEX_BITS-1:0] min_index,
	output logic                  last_of_run
);

	logic second_q;
	logic beat;

	assign empty       = head.empty;
	assign min_index   = second_q ? head.head.second : head.head.first;
	assign last_of_run = !head.head.two || second_q;
	assign beat        = pop && !head.empty;
	assign rd          = beat && last_of_run;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			second_q <= 1'b0;
		end else if (beat) begin
			second_q <= !last_of_run;
		end
	end

endmodule
